### rtl/core/tan_projection_pixel_to_sky_defines.svh
// assertion macros shared by the checker
`ifndef TAN_PROJECTION_PIXEL_TO_SKY_DEFINES_SVH
`define TAN_PROJECTION_PIXEL_TO_SKY_DEFINES_SVH

// same-cycle implication
`define TPPS_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tpps_pkg.sv
package tpps_pkg;

  localparam int unsigned CordicSteps = 30;
  localparam int unsigned CordW       = 36;
  localparam int unsigned AngW        = 34;
  localparam int unsigned RadW        = 33;
  localparam int unsigned PlaneW      = 37;

  localparam logic signed [CordW-1:0]  GainInit   = 36'sd652032874;
  localparam logic signed [30:0]       GainQ30    = 31'sd652032874;
  localparam logic signed [27:0]       Deg2RadQ32 = 28'sd74961321;
  localparam logic signed [PlaneW-1:0] PlaneMax   = {1'b0, {(PlaneW-1){1'b1}}};
  localparam logic signed [PlaneW-1:0] PlaneMin   = {1'b1, {(PlaneW-1){1'b0}}};
  localparam logic signed [AngW-1:0]   Quarter    = 34'sd1073741824;
  localparam logic signed [AngW-1:0]   NegQuarter = -34'sd1073741824;
  localparam logic signed [AngW-1:0]   HalfTurn   = 34'sd2147483648;

  localparam logic [31:0] AngleTab [CordicSteps] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef enum logic [2:0] {
    CfgMatXx   = 3'd0,
    CfgMatXy   = 3'd1,
    CfgMatYx   = 3'd2,
    CfgMatYy   = 3'd3,
    CfgRefX    = 3'd4,
    CfgRefY    = 3'd5,
    CfgRaZero  = 3'd6,
    CfgDecZero = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusZeroDen = 2'd1,
    StatusSat     = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] mat_xx;
    logic signed [31:0] mat_xy;
    logic signed [31:0] mat_yx;
    logic signed [31:0] mat_yy;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic        [31:0] ra_zero;
    logic signed [31:0] dec_zero;
  } cfg_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic signed [RadW-1:0] xr;
    logic signed [RadW-1:0] yr;
    logic                   sat;
    logic                   flip;
  } rot_side_t;

  typedef struct packed {
    logic signed [CordW-1:0] num;
    logic                    sat;
    logic                    zero_den;
  } vec1_side_t;

  typedef struct packed {
    logic signed [AngW-1:0] off;
    logic                   sat;
    logic                   zero_den;
  } vec2_side_t;

endpackage

### rtl/core/tpps_pix_if.sv
interface tpps_pix_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pixel_x;
  logic signed [31:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

### rtl/core/tpps_sky_if.sv
interface tpps_sky_if;
  logic               valid;
  logic               ready;
  logic        [31:0] ra_turns;
  logic signed [31:0] dec_turns;
  logic        [1:0]  status;

  modport source (output valid, output ra_turns, output dec_turns, output status, input ready);
  modport sink (input valid, input ra_turns, input dec_turns, input status, output ready);
endinterface

### rtl/core/tpps_plane.sv
module tpps_plane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [31:0]                pixel_x_i,
  input  logic signed [31:0]                pixel_y_i,
  input  tpps_pkg::cfg_t                    cfg_i,
  output logic                              valid_o,
  output logic signed [tpps_pkg::RadW-1:0]  xr_o,
  output logic signed [tpps_pkg::RadW-1:0]  yr_o,
  output logic                              sat_o,
  output logic                              flip_o,
  output logic signed [tpps_pkg::AngW-1:0]  z_o
);

  // stage 1: offsets and angle fold
  logic signed [32:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [tpps_pkg::AngW-1:0] zs, z1_d, z1_q;
  logic flip1_d, flip1_q;
  logic [3:0] valid_q;

  assign dx_d = {pixel_x_i[31], pixel_x_i} - {cfg_i.ref_x[31], cfg_i.ref_x};
  assign dy_d = {pixel_y_i[31], pixel_y_i} - {cfg_i.ref_y[31], cfg_i.ref_y};
  assign zs   = {{(tpps_pkg::AngW-32){cfg_i.dec_zero[31]}}, cfg_i.dec_zero};

  always_comb begin
    z1_d    = zs;
    flip1_d = 1'b0;
    if (zs > tpps_pkg::Quarter) begin
      z1_d    = zs - tpps_pkg::HalfTurn;
      flip1_d = 1'b1;
    end else if (zs < tpps_pkg::NegQuarter) begin
      z1_d    = zs + tpps_pkg::HalfTurn;
      flip1_d = 1'b1;
    end
  end

  // stage 2: matrix products
  logic signed [64:0] pxx, pxy, pyx, pyy;
  logic signed [48:0] pxx_q, pxy_q, pyx_q, pyy_q;
  logic signed [tpps_pkg::AngW-1:0] z2_q;
  logic flip2_q;

  assign pxx = dx_q * cfg_i.mat_xx;
  assign pxy = dy_q * cfg_i.mat_xy;
  assign pyx = dx_q * cfg_i.mat_yx;
  assign pyy = dy_q * cfg_i.mat_yy;

  // stage 3: sum and clamp
  logic signed [49:0] sx, sy;
  logic signed [tpps_pkg::PlaneW-1:0] px_d, py_d, px_q, py_q;
  logic sat3_d, sat3_q;
  logic signed [tpps_pkg::AngW-1:0] z3_q;
  logic flip3_q;

  assign sx = {pxx_q[48], pxx_q} + {pxy_q[48], pxy_q};
  assign sy = {pyx_q[48], pyx_q} + {pyy_q[48], pyy_q};

  always_comb begin
    sat3_d = 1'b0;
    if (sx > tpps_pkg::PlaneMax) begin
      px_d   = tpps_pkg::PlaneMax;
      sat3_d = 1'b1;
    end else if (sx < tpps_pkg::PlaneMin) begin
      px_d   = tpps_pkg::PlaneMin;
      sat3_d = 1'b1;
    end else begin
      px_d = sx[tpps_pkg::PlaneW-1:0];
    end
    if (sy > tpps_pkg::PlaneMax) begin
      py_d   = tpps_pkg::PlaneMax;
      sat3_d = 1'b1;
    end else if (sy < tpps_pkg::PlaneMin) begin
      py_d   = tpps_pkg::PlaneMin;
      sat3_d = 1'b1;
    end else begin
      py_d = sy[tpps_pkg::PlaneW-1:0];
    end
  end

  // stage 4: degrees to radians, rounded
  logic signed [64:0] mx, my, rx, ry;

  assign mx = px_q * tpps_pkg::Deg2RadQ32;
  assign my = py_q * tpps_pkg::Deg2RadQ32;
  assign rx = mx + 65'sd2147483648;
  assign ry = my + 65'sd2147483648;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      z1_q    <= z1_d;
      flip1_q <= flip1_d;
      pxx_q   <= pxx[64:16];
      pxy_q   <= pxy[64:16];
      pyx_q   <= pyx[64:16];
      pyy_q   <= pyy[64:16];
      z2_q    <= z1_q;
      flip2_q <= flip1_q;
      px_q    <= px_d;
      py_q    <= py_d;
      sat3_q  <= sat3_d;
      z3_q    <= z2_q;
      flip3_q <= flip2_q;
      xr_o    <= rx[64:32];
      yr_o    <= ry[64:32];
      sat_o   <= sat3_q;
      z_o     <= z3_q;
      flip_o  <= flip3_q;
    end
  end

  assign valid_o = valid_q[3];

endmodule

### rtl/core/tpps_cordic_step.sv
module tpps_cordic_step #(
  parameter int unsigned Step   = 0,
  parameter bit          Vector = 1'b0,
  parameter int unsigned SideW  = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tpps_pkg::cordic_t   vec_i,
  input  logic [SideW-1:0]    side_i,
  output logic                valid_o,
  output tpps_pkg::cordic_t   vec_o,
  output logic [SideW-1:0]    side_o
);

  logic signed [tpps_pkg::CordW-1:0] xs, ys;
  logic signed [tpps_pkg::AngW-1:0]  ang;
  logic                              up;
  tpps_pkg::cordic_t                 vec_d;

  assign xs  = $signed(vec_i.x) >>> Step;
  assign ys  = $signed(vec_i.y) >>> Step;
  assign ang = tpps_pkg::AngW'(tpps_pkg::AngleTab[Step]);
  // rotation steers on the angle, vectoring on the sign of y
  assign up  = Vector ? vec_i.y[tpps_pkg::CordW-1] : ~vec_i.z[tpps_pkg::AngW-1];

  always_comb begin
    if (up) begin
      vec_d.x = $signed(vec_i.x) - ys;
      vec_d.y = $signed(vec_i.y) + xs;
      vec_d.z = $signed(vec_i.z) - ang;
    end else begin
      vec_d.x = $signed(vec_i.x) + ys;
      vec_d.y = $signed(vec_i.y) - xs;
      vec_d.z = $signed(vec_i.z) + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_o  <= vec_d;
      side_o <= side_i;
    end
  end

endmodule

### rtl/core/tpps_cordic.sv
module tpps_cordic #(
  parameter bit          Vector = 1'b0,
  parameter int unsigned SideW  = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  tpps_pkg::cordic_t  vec_i,
  input  logic [SideW-1:0]   side_i,
  output logic               valid_o,
  output tpps_pkg::cordic_t  vec_o,
  output logic [SideW-1:0]   side_o
);

  logic              valid_s [tpps_pkg::CordicSteps+1];
  tpps_pkg::cordic_t vec_s   [tpps_pkg::CordicSteps+1];
  logic [SideW-1:0]  side_s  [tpps_pkg::CordicSteps+1];

  assign valid_s[0] = valid_i;
  assign vec_s[0]   = vec_i;
  assign side_s[0]  = side_i;

  for (genvar i = 0; i < tpps_pkg::CordicSteps; i++) begin : g_step
    tpps_cordic_step #(
      .Step   (i),
      .Vector (Vector),
      .SideW  (SideW)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (valid_s[i]),
      .vec_i   (vec_s[i]),
      .side_i  (side_s[i]),
      .valid_o (valid_s[i+1]),
      .vec_o   (vec_s[i+1]),
      .side_o  (side_s[i+1])
    );
  end

  assign valid_o = valid_s[tpps_pkg::CordicSteps];
  assign vec_o   = vec_s[tpps_pkg::CordicSteps];
  assign side_o  = side_s[tpps_pkg::CordicSteps];

endmodule

### rtl/core/tan_projection_pixel_to_sky.sv
// channel   dir  payload                          handshake
// pix_i     in   pixel_x, pixel_y                 valid/ready
// sky_o     out  ra_turns, dec_turns, status      valid/ready
// cfg       in   cfg_idx_i, cfg_data_i            cfg_we_i, no wait
//
// one item per cycle while sky_o is not stalled
// the pipeline is the three 30-step cordic chains plus 8 arithmetic stages
// reset clears the valid bits and the settings; data registers are not reset; no clearing pass
// a stall on sky_o freezes the whole pipeline, pix_i.ready drops with it
module tan_projection_pixel_to_sky (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  tpps_pix_if.sink          pix_i,
  tpps_sky_if.source        sky_o
);

  tpps_pkg::cfg_t cfg_d, cfg_q;
  logic           en;
  logic           out_valid_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (tpps_pkg::cfg_idx_e'(cfg_idx_i))
        tpps_pkg::CfgMatXx:   cfg_d.mat_xx   = cfg_data_i;
        tpps_pkg::CfgMatXy:   cfg_d.mat_xy   = cfg_data_i;
        tpps_pkg::CfgMatYx:   cfg_d.mat_yx   = cfg_data_i;
        tpps_pkg::CfgMatYy:   cfg_d.mat_yy   = cfg_data_i;
        tpps_pkg::CfgRefX:    cfg_d.ref_x    = cfg_data_i;
        tpps_pkg::CfgRefY:    cfg_d.ref_y    = cfg_data_i;
        tpps_pkg::CfgRaZero:  cfg_d.ra_zero  = cfg_data_i;
        tpps_pkg::CfgDecZero: cfg_d.dec_zero = cfg_data_i;
        default:              cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign en          = sky_o.ready | ~out_valid_q;
  assign pix_i.ready = en;

  // plane coordinates
  logic                             pl_valid, pl_sat, pl_flip;
  logic signed [tpps_pkg::RadW-1:0] pl_xr, pl_yr;
  logic signed [tpps_pkg::AngW-1:0] pl_z;

  tpps_plane u_plane (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (pix_i.valid),
    .pixel_x_i (pix_i.pixel_x),
    .pixel_y_i (pix_i.pixel_y),
    .cfg_i     (cfg_q),
    .valid_o   (pl_valid),
    .xr_o      (pl_xr),
    .yr_o      (pl_yr),
    .sat_o     (pl_sat),
    .flip_o    (pl_flip),
    .z_o       (pl_z)
  );

  // cos and sin of the reference declination
  tpps_pkg::cordic_t   rot_in, rot_out;
  tpps_pkg::rot_side_t rot_side_in, rot_side_out;
  logic                rot_valid;

  assign rot_in.x    = tpps_pkg::GainInit;
  assign rot_in.y    = '0;
  assign rot_in.z    = pl_z;
  assign rot_side_in = '{xr: pl_xr, yr: pl_yr, sat: pl_sat, flip: pl_flip};

  tpps_cordic #(
    .Vector (1'b0),
    .SideW  ($bits(tpps_pkg::rot_side_t))
  ) u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pl_valid),
    .vec_i   (rot_in),
    .side_i  (rot_side_in),
    .valid_o (rot_valid),
    .vec_o   (rot_out),
    .side_o  (rot_side_out)
  );

  // products with y
  logic signed [tpps_pkg::CordW-1:0] cs, sn, c4_q, s4_q;
  logic signed [68:0]                pys, pyc;
  logic signed [38:0]                pys_q, pyc_q;
  logic signed [tpps_pkg::RadW-1:0]  xr1_q, xr2_q;
  logic                              sat1_q, sat2_q, m1_valid_q, m2_valid_q;

  assign cs  = rot_side_out.flip ? -$signed(rot_out.x) : $signed(rot_out.x);
  assign sn  = rot_side_out.flip ? -$signed(rot_out.y) : $signed(rot_out.y);
  assign pys = $signed(rot_side_out.yr) * sn;
  assign pyc = $signed(rot_side_out.yr) * cs;

  // denominator and numerator
  logic signed [38:0]                den_w, num_w;
  logic signed [tpps_pkg::CordW-1:0] den_q, num_q;
  logic                              zero_den_q;

  assign den_w = c4_q - pys_q;
  assign num_w = s4_q + pyc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
      m2_valid_q <= 1'b0;
    end else if (en) begin
      m1_valid_q <= rot_valid;
      m2_valid_q <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_q       <= cs >>> 2;
      s4_q       <= sn >>> 2;
      pys_q      <= pys[68:30];
      pyc_q      <= pyc[68:30];
      xr1_q      <= rot_side_out.xr;
      sat1_q     <= rot_side_out.sat;
      den_q      <= den_w[tpps_pkg::CordW-1:0];
      num_q      <= num_w[tpps_pkg::CordW-1:0];
      zero_den_q <= (den_w == '0) && (xr1_q == '0);
      xr2_q      <= xr1_q;
      sat2_q     <= sat1_q;
    end
  end

  // ra offset and radius
  tpps_pkg::cordic_t                 v1_in, v1_out;
  tpps_pkg::vec1_side_t              v1_side_in, v1_side_out;
  logic                              v1_valid;
  logic signed [tpps_pkg::CordW-1:0] xr_ext;

  assign xr_ext     = {{(tpps_pkg::CordW-tpps_pkg::RadW){xr2_q[tpps_pkg::RadW-1]}}, xr2_q};
  assign v1_in.x    = den_q[tpps_pkg::CordW-1] ? -den_q : den_q;
  assign v1_in.y    = den_q[tpps_pkg::CordW-1] ? -xr_ext : xr_ext;
  assign v1_in.z    = '0;
  assign v1_side_in = '{num: num_q, sat: sat2_q, zero_den: zero_den_q};

  tpps_cordic #(
    .Vector (1'b1),
    .SideW  ($bits(tpps_pkg::vec1_side_t))
  ) u_vec_ra (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m2_valid_q),
    .vec_i   (v1_in),
    .side_i  (v1_side_in),
    .valid_o (v1_valid),
    .vec_o   (v1_out),
    .side_o  (v1_side_out)
  );

  // gain correction of the radius
  logic signed [66:0]                rmul;
  logic signed [tpps_pkg::CordW-1:0] r_q, num3_q;
  logic signed [tpps_pkg::AngW-1:0]  off_q;
  logic                              sat3_q, zero_den3_q, g_valid_q;

  assign rmul = $signed(v1_out.x) * tpps_pkg::GainQ30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= 1'b0;
    end else if (en) begin
      g_valid_q <= v1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q         <= rmul[tpps_pkg::CordW+29:30];
      num3_q      <= v1_side_out.num;
      off_q       <= v1_out.z;
      sat3_q      <= v1_side_out.sat;
      zero_den3_q <= v1_side_out.zero_den;
    end
  end

  // declination
  tpps_pkg::cordic_t    v2_in, v2_out;
  tpps_pkg::vec2_side_t v2_side_in, v2_side_out;
  logic                 v2_valid;

  assign v2_in.x    = r_q;
  assign v2_in.y    = num3_q;
  assign v2_in.z    = '0;
  assign v2_side_in = '{off: off_q, sat: sat3_q, zero_den: zero_den3_q};

  tpps_cordic #(
    .Vector (1'b1),
    .SideW  ($bits(tpps_pkg::vec2_side_t))
  ) u_vec_dec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g_valid_q),
    .vec_i   (v2_in),
    .side_i  (v2_side_in),
    .valid_o (v2_valid),
    .vec_o   (v2_out),
    .side_o  (v2_side_out)
  );

  // output register
  logic signed [tpps_pkg::AngW-1:0] dec_c;
  logic        [31:0]               ra_d, ra_q;
  logic signed [31:0]               dec_d, dec_q;
  tpps_pkg::status_e                status_d, status_q;

  always_comb begin
    if ($signed(v2_out.z) > tpps_pkg::Quarter) begin
      dec_c = tpps_pkg::Quarter;
    end else if ($signed(v2_out.z) < tpps_pkg::NegQuarter) begin
      dec_c = tpps_pkg::NegQuarter;
    end else begin
      dec_c = v2_out.z;
    end
    if (v2_side_out.zero_den) begin
      ra_d     = '0;
      dec_d    = '0;
      status_d = tpps_pkg::StatusZeroDen;
    end else begin
      ra_d     = cfg_q.ra_zero + v2_side_out.off[31:0];
      dec_d    = dec_c[31:0];
      status_d = v2_side_out.sat ? tpps_pkg::StatusSat : tpps_pkg::StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_q     <= ra_d;
      dec_q    <= dec_d;
      status_q <= status_d;
    end
  end

  assign sky_o.valid     = out_valid_q;
  assign sky_o.ra_turns  = ra_q;
  assign sky_o.dec_turns = dec_q;
  assign sky_o.status    = status_q;

endmodule

### rtl/core/tpps_checker.sv
`include "tan_projection_pixel_to_sky_defines.svh"

module tpps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic        [31:0] ra_i,
  input logic signed [31:0] dec_i,
  input logic        [1:0]  status_i
);

  logic        ready_ok, zd_out, zd_clear, dec_ok, stall;
  logic [66:0] item;

  assign ready_ok = in_ready_i == (out_ready_i || !out_valid_i);
  assign zd_out   = out_valid_i && (status_i == tpps_pkg::StatusZeroDen);
  assign zd_clear = (ra_i == 32'd0) && (dec_i == 32'sd0);
  assign dec_ok   = (dec_i <= 32'sd1073741824) && (dec_i >= -32'sd1073741824);
  assign stall    = out_valid_i && !out_ready_i;
  assign item     = {out_valid_i, ra_i, dec_i, status_i};

  `TPPS_ASSERT_HOLDS(a_ready_tracks_out, clk_i, rst_ni, 1'b1, ready_ok, "input ready off output")
  `TPPS_ASSERT_HOLDS(a_zero_den_fields, clk_i, rst_ni, zd_out, zd_clear, "zero den fields set")
  `TPPS_ASSERT_HOLDS(a_dec_range, clk_i, rst_ni, out_valid_i, dec_ok, "declination out of range")
  `TPPS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stall, $stable(item), "stalled item changed")

endmodule

bind tan_projection_pixel_to_sky tpps_checker u_tpps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (sky_o.valid),
  .out_ready_i (sky_o.ready),
  .ra_i        (sky_o.ra_turns),
  .dec_i       (sky_o.dec_turns),
  .status_i    (sky_o.status)
);

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 110;
  localparam longint PlaneHi = (longint'(1) <<< 36) - 1;
  localparam longint PlaneLo = -(longint'(1) <<< 36);
  localparam longint QuarterL = longint'(1) <<< 30;
  localparam longint HalfL = longint'(1) <<< 31;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pixel_t;

  typedef struct packed {
    logic        [31:0] ra;
    logic signed [31:0] dec;
    tpps_pkg::status_e  status;
  } sky_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  tpps_pix_if pix ();
  tpps_sky_if sky ();

  tan_projection_pixel_to_sky DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .sky_o      (sky)
  );

  always #1 clk_i = ~clk_i;

  logic [31:0] wcs [8];
  pixel_t pending_pixels [$];
  sky_t   expected_sky [$];
  bit     calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned sky_seen = 0;
  int unsigned zero_den_seen = 0;
  int unsigned sat_seen = 0;
  int unsigned quiet_cycles = 0;

  function automatic void rotate_dec(input longint angle, output longint c, output longint s);
    longint x, y, z, xs, ys;
    bit flip;
    x = longint'(tpps_pkg::GainQ30);
    y = 0;
    z = angle;
    flip = 1'b0;
    if (z > QuarterL) begin
      z -= HalfL;
      flip = 1'b1;
    end else if (z < -QuarterL) begin
      z += HalfL;
      flip = 1'b1;
    end
    for (int i = 0; i < tpps_pkg::CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(tpps_pkg::AngleTab[i]);
      end else begin
        x += ys; y -= xs; z += longint'(tpps_pkg::AngleTab[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void polar(input longint xi, input longint yi,
                                output longint ang, output longint mag);
    longint x, y, z, xs, ys;
    x = xi;
    y = yi;
    z = 0;
    for (int i = 0; i < tpps_pkg::CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(tpps_pkg::AngleTab[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(tpps_pkg::AngleTab[i]);
      end
    end
    ang = z;
    mag = (x * longint'(tpps_pkg::GainQ30)) >>> 30;
  endfunction

  function automatic sky_t project(input pixel_t p);
    sky_t res;
    longint dx, dy, pxd, pyd, xr, yr, c, s, den, num, off, r, dec, spare;
    bit sat;
    dx = longint'(p.x) - longint'($signed(wcs[tpps_pkg::CfgRefX]));
    dy = longint'(p.y) - longint'($signed(wcs[tpps_pkg::CfgRefY]));
    pxd = ((longint'($signed(wcs[tpps_pkg::CfgMatXx])) * dx) >>> 16)
        + ((longint'($signed(wcs[tpps_pkg::CfgMatXy])) * dy) >>> 16);
    pyd = ((longint'($signed(wcs[tpps_pkg::CfgMatYx])) * dx) >>> 16)
        + ((longint'($signed(wcs[tpps_pkg::CfgMatYy])) * dy) >>> 16);
    sat = 1'b0;
    if (pxd > PlaneHi) begin pxd = PlaneHi; sat = 1'b1; end
    if (pxd < PlaneLo) begin pxd = PlaneLo; sat = 1'b1; end
    if (pyd > PlaneHi) begin pyd = PlaneHi; sat = 1'b1; end
    if (pyd < PlaneLo) begin pyd = PlaneLo; sat = 1'b1; end
    xr = (pxd * longint'(tpps_pkg::Deg2RadQ32) + HalfL) >>> 32;
    yr = (pyd * longint'(tpps_pkg::Deg2RadQ32) + HalfL) >>> 32;
    rotate_dec(longint'($signed(wcs[tpps_pkg::CfgDecZero])), c, s);
    den = (c >>> 2) - ((yr * s) >>> 30);
    num = (s >>> 2) + ((yr * c) >>> 30);
    if (den == 0 && xr == 0) begin
      res.ra = '0;
      res.dec = '0;
      res.status = tpps_pkg::StatusZeroDen;
      return res;
    end
    if (den < 0) polar(-den, -xr, off, r);
    else polar(den, xr, off, r);
    polar(r, num, dec, spare);
    if (dec > QuarterL) dec = QuarterL;
    if (dec < -QuarterL) dec = -QuarterL;
    res.ra = wcs[tpps_pkg::CfgRaZero] + off[31:0];
    res.dec = dec[31:0];
    res.status = sat ? tpps_pkg::StatusSat : tpps_pkg::StatusOk;
    return res;
  endfunction

  // pixel driver, predicts on every accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t p, got;
    if (!rst_ni) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) begin
        got.x = pix.pixel_x;
        got.y = pix.pixel_y;
        expected_sky = {expected_sky, project(got)};
        pixels_sent++;
      end
      if (!pix.valid || pix.ready) begin
        if (pending_pixels.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
          p = pending_pixels.pop_front();
          pix.pixel_x <= p.x;
          pix.pixel_y <= p.y;
          pix.valid <= 1'b1;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // sky monitor and back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sky.ready <= 1'b0;
    end else begin
      sky.ready <= calm || ($urandom_range(99) >= 16);
      if (sky.valid && sky.ready) begin
        sky_seen++;
        if (expected_sky.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item ra=%h dec=%h status=%0d",
                     sky.ra_turns, sky.dec_turns, sky.status);
        end else begin
          sky_t e;
          e = expected_sky.pop_front();
          if (e.status == tpps_pkg::StatusZeroDen) zero_den_seen++;
          if (e.status == tpps_pkg::StatusSat) sat_seen++;
          if (sky.ra_turns !== e.ra || sky.dec_turns !== e.dec ||
              sky.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected ra=%h dec=%h status=%0d, got ra=%h dec=%h status=%0d",
                       e.ra, e.dec, e.status,
                       sky.ra_turns, sky.dec_turns, sky.status);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (sky.valid && sky.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("timeout with %0d items outstanding", expected_sky.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic load_wcs(input logic [31:0] v [8]);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= tpps_pkg::cfg_idx_e'(i);
      cfg_data_i <= v[i];
      wcs[i] = v[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    while (pending_pixels.size() > 0 || pix.valid || expected_sky.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send(input logic [31:0] x, input logic [31:0] y);
    pixel_t p;
    p.x = x;
    p.y = y;
    pending_pixels = {pending_pixels, p};
  endtask

  function automatic logic [31:0] near(input logic [31:0] centre);
    return centre + $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
  endfunction

  initial begin
    logic [31:0] v [8];
    logic [31:0] zero_y;
    pixel_t probe;
    real a, est;
    pix.valid = 1'b0;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    sky.ready = 1'b0;
    for (int i = 0; i < 8; i++) wcs[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, pixel extremes
    send(32'h0, 32'h0);
    send(32'h7fff_ffff, 32'h7fff_ffff);
    send(32'h8000_0000, 32'h8000_0000);
    send(32'h7fff_ffff, 32'h8000_0000);
    send(32'h0001_0000, 32'hffff_0000);
    drain();

    // matrix, reference and ra registers at their extremes, declination at the north pole, saturating plane
    v = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h4000_0000};
    load_wcs(v);
    send(32'h7fff_ffff, 32'h8000_0000);
    send(32'h8000_0000, 32'h7fff_ffff);
    send(32'h0, 32'h0);
    send(32'h7fff_ffff, 32'h7fff_ffff);
    drain();

    // south pole and an out-of-range reference declination
    v = '{32'h0000_1000, 32'h0, 32'h0, 32'hffff_f000, 32'h0, 32'h0, 32'h0, 32'hc000_0000};
    load_wcs(v);
    send(32'h0, 32'h0);
    send(32'h0010_0000, 32'hfff0_0000);
    drain();
    v[tpps_pkg::CfgDecZero] = 32'h8000_0000;
    v[tpps_pkg::CfgRaZero] = 32'h8000_0000;
    load_wcs(v);
    send(32'h0, 32'h0);
    send(32'hfff0_0000, 32'h0030_0000);
    drain();

    // zero denominator: find the row where the plane meets the horizon
    v = '{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h1234_5678,
          32'd1009317315};
    load_wcs(v);
    a = 1009317315.0 / 4294967296.0 * 2.0 * 3.14159265358979;
    est = 268435456.0 * $cos(a) / $sin(a) * 4294967296.0 / 74961321.0;
    zero_y = $rtoi(est);
    for (int k = -400; k <= 400; k++) begin
      probe.x = 32'h0;
      probe.y = $rtoi(est) + k;
      if (project(probe).status == tpps_pkg::StatusZeroDen) begin
        zero_y = $rtoi(est) + k;
        break;
      end
    end
    send(32'h0, zero_y);
    send(32'h0000_1000, zero_y);
    send(32'hffff_f000, zero_y);
    send(32'h0, zero_y + 1);
    drain();

    // random settings and pixels
    for (int ph = 0; ph < 9; ph++) begin
      for (int i = 0; i < 4; i++)
        v[i] = ($urandom_range(3) == 0) ? $urandom()
             : $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      v[tpps_pkg::CfgRefX] = $urandom();
      v[tpps_pkg::CfgRefY] = $urandom();
      v[tpps_pkg::CfgRaZero] = $urandom();
      v[tpps_pkg::CfgDecZero] = ($urandom_range(4) == 0) ? $urandom()
                    : $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
      load_wcs(v);
      calm = (ph == 4);
      for (int n = 0; n < 110; n++) begin
        if ($urandom_range(9) < 7)
          send(near(v[tpps_pkg::CfgRefX]), near(v[tpps_pkg::CfgRefY]));
        else send($urandom(), $urandom());
      end
      drain();
    end
    calm = 1'b0;

    $display("%0d pixels projected, %0d sky items checked", pixels_sent, sky_seen);
    $display("%0d zero-denominator and %0d saturated items among them",
             zero_den_seen, sat_seen);
    if (mismatches == 0 && expected_sky.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl/core
rtl/core/tpps_pkg.sv
rtl/core/tpps_pix_if.sv
rtl/core/tpps_sky_if.sv
rtl/core/tpps_plane.sv
rtl/core/tpps_cordic_step.sv
rtl/core/tpps_cordic.sv
rtl/core/tan_projection_pixel_to_sky.sv
rtl/core/tpps_checker.sv
test/tb_top.sv
